[sv/rgb565_rect_payload_decoder_macros.svh]
// assertion macros for the rgb565 rectangle payload decoder
`ifndef RGB565_RECT_PAYLOAD_DECODER_MACROS_SVH
`define RGB565_RECT_PAYLOAD_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every edge outside reset
`define RGBRECT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rgbrect assertion failed");

// condition that must never be seen outside reset
`define RGBRECT_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("rgbrect forbidden condition seen");

`else

`define RGBRECT_ASSERT(lbl, clk, rstn, prop)
`define RGBRECT_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[sv/rgbrect_pkg.sv]
package rgbrect_pkg;

    // default header limits
    localparam int MAX_WIDTH_DEF  = 240;
    localparam int MAX_HEIGHT_DEF = 240;

    // pixel count of a rectangle: 10-bit width times 8-bit height
    localparam int PIX_W   = 18;
    localparam int BYTES_W = 18;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // encodings
    localparam logic [1:0] ENC_RAW = 2'd0;
    localparam logic [1:0] ENC_RLE = 2'd1;

    // byte position inside a raw pair or a run-length triple
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    // result codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_HEADER   = 3'd1;
    localparam logic [2:0] ERR_ZERO_RUN = 3'd2;
    localparam logic [2:0] ERR_OVERRUN  = 3'd3;
    localparam logic [2:0] ERR_TRAILING = 3'd4;
    localparam logic [2:0] ERR_SHORT    = 3'd5;

    typedef struct packed {
        logic        kind;
        logic [1:0]  encoding;
        logic [9:0]  rect_width;
        logic [7:0]  rect_height;
        logic [17:0] payload_bytes;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic [7:0]  repeat_res;
        logic        last;
        logic [2:0]  error_code;
    } out_t;

    typedef struct packed {
        logic               active;
        logic               mode_rle;
        logic [1:0]         byte_phase;
        logic [7:0]         held_count;
        logic [7:0]         held_low;
        logic [PIX_W-1:0]   pixels_left;
        logic [BYTES_W-1:0] bytes_left;
    } state_t;

    // divisibility by 3: base-4 digits are summed since 4 is 1 modulo 3
    function automatic logic mod3_zero(input logic [17:0] v);
        logic [4:0] s;
        logic [2:0] s2;
        logic [2:0] s3;
        s = '0;
        for (int i = 0; i < 9; i++) begin
            s = s + {3'b0, v[2*i +: 2]};
        end
        s2 = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b0, s[4]};
        s3 = {1'b0, s2[1:0]} + {2'b0, s2[2]};
        return (s3 == 3'd0) || (s3 == 3'd3);
    endfunction

endpackage

[sv/rgbrect_step.sv]
module rgbrect_step import rgbrect_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  in_t    item,
    input  state_t st,
    output state_t st_next,
    output logic   res_valid,
    output out_t   res
);

    localparam logic [9:0] MAX_W = 10'(MAX_WIDTH);
    localparam logic [9:0] MAX_H = 10'(MAX_HEIGHT);

    logic [PIX_W-1:0]   total;
    logic               hdr_bad;
    logic [BYTES_W-1:0] bytes_dec;
    logic [PIX_W-1:0]   pix_raw;
    logic [PIX_W-1:0]   pix_rle;
    logic [15:0]        pix_val;

    // header checks
    assign total = {8'b0, item.rect_width} * {10'b0, item.rect_height};

    always_comb begin
        hdr_bad = (item.encoding != ENC_RAW && item.encoding != ENC_RLE)
                  || (item.rect_width > MAX_W)
                  || ({2'b0, item.rect_height} > MAX_H);
        if (!hdr_bad && item.encoding == ENC_RAW
            && {1'b0, item.payload_bytes} != {total, 1'b0}) begin
            hdr_bad = 1'b1;
        end
        if (!hdr_bad && item.encoding == ENC_RLE
            && (item.payload_bytes == '0 || !mod3_zero(item.payload_bytes))) begin
            hdr_bad = 1'b1;
        end
    end

    // counters after this beat
    assign bytes_dec = (st.bytes_left != '0) ? st.bytes_left - 1'b1 : st.bytes_left;
    assign pix_raw   = st.pixels_left - 1'b1;
    assign pix_rle   = st.pixels_left - {{(PIX_W-8){1'b0}}, st.held_count};
    assign pix_val   = {item.data_byte, st.held_low};

    // per-beat decode
    always_comb begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '0;
        res.last  = 1'b1;
        if (item.kind == KIND_START) begin
            st_next.active     = 1'b0;
            st_next.byte_phase = PH_FIRST;
            if (hdr_bad) begin
                res_valid      = 1'b1;
                res.error_code = ERR_HEADER;
            end else if (total == '0) begin
                res_valid      = 1'b1;
                res.error_code = (item.encoding == ENC_RAW) ? ERR_OK : ERR_TRAILING;
            end else begin
                st_next.active      = 1'b1;
                st_next.mode_rle    = (item.encoding == ENC_RLE);
                st_next.held_count  = '0;
                st_next.held_low    = '0;
                st_next.pixels_left = total;
                st_next.bytes_left  = item.payload_bytes;
            end
        end else if (st.active) begin
            st_next.bytes_left = bytes_dec;
            if (!st.mode_rle) begin
                // raw: little-endian pair gives one pixel
                if (st.byte_phase == PH_FIRST) begin
                    st_next.held_low   = item.data_byte;
                    st_next.byte_phase = PH_SECOND;
                end else begin
                    st_next.byte_phase  = PH_FIRST;
                    st_next.pixels_left = pix_raw;
                    res_valid           = 1'b1;
                    res.pixel           = pix_val;
                    res.repeat_res      = 8'd1;
                    res.last            = (pix_raw == '0);
                    res.error_code      = ERR_OK;
                    if (pix_raw == '0) begin
                        st_next.active = 1'b0;
                    end
                end
            end else begin
                // run-length: count, low, high
                case (st.byte_phase)
                    PH_FIRST: begin
                        if (item.data_byte == 8'd0) begin
                            st_next.active = 1'b0;
                            res_valid      = 1'b1;
                            res.error_code = ERR_ZERO_RUN;
                        end else if ({{(PIX_W-8){1'b0}}, item.data_byte} > st.pixels_left) begin
                            st_next.active = 1'b0;
                            res_valid      = 1'b1;
                            res.error_code = ERR_OVERRUN;
                        end else begin
                            st_next.held_count = item.data_byte;
                            st_next.byte_phase = PH_SECOND;
                        end
                    end
                    PH_SECOND: begin
                        st_next.held_low   = item.data_byte;
                        st_next.byte_phase = PH_THIRD;
                    end
                    default: begin
                        st_next.byte_phase  = PH_FIRST;
                        st_next.pixels_left = pix_rle;
                        res_valid           = 1'b1;
                        if (pix_rle == '0 && bytes_dec != '0) begin
                            st_next.active = 1'b0;
                            res.error_code = ERR_TRAILING;
                        end else if (pix_rle != '0 && bytes_dec == '0) begin
                            st_next.active = 1'b0;
                            res.error_code = ERR_SHORT;
                        end else begin
                            res.pixel      = pix_val;
                            res.repeat_res = st.held_count;
                            res.last       = (pix_rle == '0);
                            res.error_code = ERR_OK;
                            if (pix_rle == '0) begin
                                st_next.active = 1'b0;
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

[sv/rgb565_rect_payload_decoder.sv]
// rgb565 rectangle payload decoder
//
// input channel (s_): one beat is either a rectangle start carrying the
// header (encoding, width, height, payload length) or one payload byte.
// result channel (m_): zero or one pixel run per input beat, in raster
// order; the run that ends a rectangle, or the first error, has last set.
//
// a beat passes the input register, then the result register, before its
// result is held on m_. throughput: one beat per cycle while a held result
// does not stall the result register with m_ready low; the decode of a beat
// is a single pass through rgbrect_step.
//
// reset (aresetn low, synchronous) empties both registers and leaves the
// decoder idle; payload bytes seen while idle are dropped silently.
// when m_ready is low with a result held, the input register fills and
// s_ready then drops; nothing is lost or repeated.
`include "rgb565_rect_payload_decoder_macros.svh"

module rgb565_rect_payload_decoder import rgbrect_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic   in_valid_reg;
    logic   in_valid_next;
    in_t    in_reg;
    state_t st_reg;
    state_t st_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    out_t   m_data_reg;
    logic   res_valid;
    out_t   res;
    logic   adv;

    // the input register drains when the result register can take a beat
    assign adv     = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    rgbrect_step #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_step (
        .item      (in_reg),
        .st        (st_reg),
        .st_next   (st_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // handshake bookkeeping
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
        if (adv) begin
            m_valid_next = res_valid;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            st_reg       <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (adv) begin
                st_reg <= st_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (adv && res_valid) begin
            m_data_reg <= res;
        end
    end

    // checks on the decoder's own bookkeeping
    `RGBRECT_ASSERT(a_err_zero_run, aclk, aresetn,
        m_valid && m_data.error_code != ERR_OK
        |-> m_data.pixel == '0 && m_data.repeat_res == '0 && m_data.last)
    `RGBRECT_ASSERT(a_mid_ok, aclk, aresetn,
        m_valid && !m_data.last |-> m_data.error_code == ERR_OK && m_data.repeat_res != '0)
    `RGBRECT_ASSERT(a_active_pixels, aclk, aresetn, st_reg.active |-> st_reg.pixels_left != '0)
    `RGBRECT_ASSERT_NEVER(a_raw_phase, aclk, aresetn,
        st_reg.active
        && (st_reg.byte_phase == 2'd3 || (!st_reg.mode_rle && st_reg.byte_phase == PH_THIRD)))

endmodule
